// ===== sv/lprs_pkg.sv =====
// Package for the LED panel refresh scheduler: payload types, action codes,
// frame constants and the key and backlight frame tables. No dependencies.
package lprs_pkg;

    localparam int PANEL_SLOTS      = 8;
    localparam int SLOT_W           = (PANEL_SLOTS > 1) ? $clog2(PANEL_SLOTS) : 1;
    localparam int FRAME_BYTES      = 8;
    localparam int ROM_ROWS         = 33;
    localparam int ROW_W            = 6;
    localparam int BACKLIGHT_FRAMES = 6;

    localparam logic [2:0] KEY_MASK       = 3'h7;
    localparam logic [7:0] FRAME_START    = 8'h7E;
    localparam logic [7:0] FRAME_LEN_CODE = 8'h02;
    localparam logic [7:0] CMD_KEYS       = 8'hC1;
    localparam logic [7:0] CMD_BACKLIGHT  = 8'h41;
    localparam logic [7:0] INTERVAL_RESET = 8'h02;

    localparam logic [2:0] ACT_SET_KEY   = 3'd0;
    localparam logic [2:0] ACT_REFRESH   = 3'd1;
    localparam logic [2:0] ACT_BACKLIGHT = 3'd2;
    localparam logic [2:0] ACT_TICK      = 3'd3;
    localparam logic [2:0] ACT_PROCESS   = 3'd4;
    localparam logic [2:0] ACT_STATUS    = 3'd5;

    localparam logic [1:0] REG_SEND_INTERVAL = 2'd0;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] panel_address;
        logic [7:0] key_number;
        logic       key_on;
        logic       rx_busy;
    } t_in;

    typedef struct packed {
        logic       out_kind;
        logic [7:0] tx_byte;
        logic       last;
        logic       has_pending;
    } t_out;

    // Key frame table row: address, state, checksum.
    typedef struct packed {
        logic [7:0] addr;
        logic [2:0] state;
        logic [7:0] chk;
    } t_rom_row;

    function automatic t_rom_row key_rom(input logic [ROW_W-1:0] r);
        t_rom_row v;
        v = '{8'h00, 3'd0, 8'h00};
        case (r)
            6'd0:  v = '{8'h01, 3'd1, 8'h44};
            6'd1:  v = '{8'h07, 3'd0, 8'h46};
            6'd2:  v = '{8'h07, 3'd1, 8'h4E};
            6'd3:  v = '{8'h07, 3'd2, 8'hE0};
            6'd4:  v = '{8'h07, 3'd3, 8'h46};
            6'd5:  v = '{8'h0D, 3'd0, 8'h60};
            6'd6:  v = '{8'h0D, 3'd1, 8'h08};
            6'd7:  v = '{8'h0D, 3'd2, 8'h6A};
            6'd8:  v = '{8'h0D, 3'd3, 8'h80};
            6'd9:  v = '{8'h0D, 3'd4, 8'h66};
            6'd10: v = '{8'h0D, 3'd5, 8'h06};
            6'd11: v = '{8'h0E, 3'd0, 8'h68};
            6'd12: v = '{8'h0E, 3'd1, 8'h6A};
            6'd13: v = '{8'h0E, 3'd2, 8'h60};
            6'd14: v = '{8'h0E, 3'd3, 8'hE6};
            6'd15: v = '{8'h0E, 3'd4, 8'hE6};
            6'd16: v = '{8'h0E, 3'd5, 8'hEE};
            6'd17: v = '{8'h0E, 3'd6, 8'hE4};
            6'd18: v = '{8'h0E, 3'd7, 8'h64};
            6'd19: v = '{8'h0F, 3'd0, 8'h6A};
            6'd20: v = '{8'h0F, 3'd1, 8'hE0};
            6'd21: v = '{8'h0F, 3'd2, 8'hE6};
            6'd22: v = '{8'h0F, 3'd3, 8'hE6};
            6'd23: v = '{8'h0F, 3'd4, 8'hEE};
            6'd24: v = '{8'h0F, 3'd5, 8'hE4};
            6'd25: v = '{8'h0F, 3'd6, 8'hE4};
            6'd26: v = '{8'h0F, 3'd7, 8'hEA};
            6'd27: v = '{8'h11, 3'd1, 8'h86};
            6'd28: v = '{8'h11, 3'd0, 8'h06};
            6'd29: v = '{8'h12, 3'd2, 8'hE4};
            6'd30: v = '{8'h12, 3'd3, 8'hA4};
            6'd31: v = '{8'h12, 3'd0, 8'h46};
            6'd32: v = '{8'h12, 3'd1, 8'h6E};
            default: v = '{8'h00, 3'd0, 8'h00};
        endcase
        return v;
    endfunction

    // Backlight-off frame: address, data, checksum.
    typedef struct packed {
        logic [7:0] addr;
        logic [7:0] data;
        logic [7:0] chk;
    } t_bl_row;

    function automatic t_bl_row backlight_rom(input logic [2:0] s);
        t_bl_row v;
        v = '{8'h07, 8'h01, 8'h4E};
        case (s)
            3'd1: v = '{8'h0D, 8'h00, 8'hEA};
            3'd2: v = '{8'h0E, 8'h00, 8'hEA};
            3'd3: v = '{8'h0F, 8'h00, 8'hAE};
            3'd4: v = '{8'h11, 8'h01, 8'hAE};
            3'd5: v = '{8'h12, 8'h02, 8'hE4};
            default: v = '{8'h07, 8'h01, 8'h4E};
        endcase
        return v;
    endfunction

    // Frame description handed from the sequencer to the byte emitter.
    typedef struct packed {
        logic [7:0] addr;
        logic [7:0] cmd;
        logic [7:0] data;
        logic [7:0] chk;
        logic       pend;
    } t_frame;

endpackage

// ===== sv/lprs_tx.sv =====
// Frame byte emitter: serializes one eight-byte frame; each byte is decoded from the registered frame and byte index.
// Depends on lprs_pkg.
module lprs_tx (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  lprs_pkg::t_frame i_frame,
    output logic            o_busy,
    output logic            o_valid,
    input  logic            i_ready,
    output lprs_pkg::t_out  o_data
);
    logic             r_busy, n_busy;
    logic [2:0]       r_idx, n_idx;
    lprs_pkg::t_frame r_frame;
    logic [7:0]       w_byte;

    always_comb begin
        case (r_idx)
            3'd0: w_byte = lprs_pkg::FRAME_START;
            3'd1: w_byte = lprs_pkg::FRAME_LEN_CODE;
            3'd2: w_byte = r_frame.addr;
            3'd3: w_byte = r_frame.cmd;
            3'd4: w_byte = r_frame.data;
            3'd7: w_byte = r_frame.chk;
            default: w_byte = 8'h00;
        endcase
    end

    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        if (i_start) begin
            n_busy = 1'b1;
            n_idx  = 3'd0;
        end else if (r_busy && i_ready) begin
            n_idx = r_idx + 3'd1;
            if (r_idx == 3'(lprs_pkg::FRAME_BYTES - 1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 3'd0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
        end
        if (i_start) begin
            r_frame <= i_frame;
        end
    end

    assign o_busy  = r_busy;
    assign o_valid = r_busy;
    assign o_data  = '{1'b0, w_byte, r_idx == 3'(lprs_pkg::FRAME_BYTES - 1), r_frame.pend};
endmodule

// ===== sv/led_panel_refresh_scheduler.sv =====
// LED panel refresh scheduler top level: slot table, scan and table-search
// sequencer, configuration port. Depends on lprs_pkg and lprs_tx.
// Set key compares one slot per cycle, then updates the table. Process scans
// one slot per cycle, then searches the 33-row key table one row per cycle (or
// takes the next backlight frame), then emits eight bytes, one per cycle while the receiver is ready.
// One request is worked at a time.
// Reset is synchronous; the slot table and control state are cleared at once, no clearing pass.
module led_panel_refresh_scheduler (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  lprs_pkg::t_in   i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output lprs_pkg::t_out  o_data,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [1:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);
    localparam int N = lprs_pkg::PANEL_SLOTS;
    localparam int SW = lprs_pkg::SLOT_W;
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_KEY   = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_ROM   = 3'd3;
    localparam logic [2:0] ST_STAT  = 3'd4;
    localparam logic [2:0] ST_TX    = 3'd5;
    localparam logic [2:0] ST_PEND  = 3'd6;

    logic [7:0] r_addr [N];
    logic [2:0] r_want [N];
    logic [2:0] r_sent [N];
    logic [N-1:0] r_pend;
    logic [7:0] r_interval, r_cool;
    logic [SW-1:0] r_next;
    logic       r_bl_armed;
    logic [2:0] r_bl_step;

    logic [2:0]    r_state;
    lprs_pkg::t_in r_req;
    logic [5:0]    r_cnt;      // slot offset or table row
    logic [SW-1:0] r_slot;
    logic          r_found, r_free_ok;
    logic [SW-1:0] r_free;
    logic          r_stat_valid, r_stat_hp;
    logic          r_after;    // final has_pending latched for the frame

    logic             tx_start, tx_busy, tx_valid;
    lprs_pkg::t_frame tx_frame;
    lprs_pkg::t_out   tx_data;

    logic [N-1:0] w_live;
    logic         w_any;
    always_comb begin
        for (int i = 0; i < N; i++) begin
            w_live[i] = (r_addr[i] != 8'h00) && r_pend[i];
        end
        w_any = r_bl_armed || (|w_live);
    end

    logic [SW-1:0] w_idx;
    logic          w_key_ok;
    logic [2:0]    w_mask;
    lprs_pkg::t_rom_row w_row;
    logic [2:0]    w_nw;
    assign w_idx = SW'((32'(r_next) + 32'(r_cnt)) % N);
    assign w_key_ok = (r_req.key_number >= 8'd1) && (r_req.key_number <= 8'd6)
                      && (r_req.panel_address != 8'h00);
    assign w_mask = (r_req.key_number <= 8'd3) ? 3'(3'd1 << (r_req.key_number[1:0] - 2'd1))
                                               : 3'd0;
    assign w_row = lprs_pkg::key_rom(r_cnt);
    always_comb begin
        logic [2:0] b;
        b = r_found ? r_want[r_slot] : 3'd0;
        w_nw = (r_req.key_on ? (b | w_mask) : (b & ~w_mask)) & lprs_pkg::KEY_MASK;
    end

    assign tx_start = 1'b0 || ((r_state == ST_ROM) && (r_cnt < 6'(lprs_pkg::ROM_ROWS))
                       && (w_row.addr == r_addr[r_slot]) && (w_row.state == r_want[r_slot]))
                      || ((r_state == ST_SCAN) && (r_cnt == 6'(N)) && r_bl_armed);
    always_comb begin
        lprs_pkg::t_bl_row bl;
        bl = lprs_pkg::backlight_rom(r_bl_step);
        if (r_state == ST_ROM) begin
            tx_frame = '{w_row.addr, lprs_pkg::CMD_KEYS, {5'd0, w_row.state}, w_row.chk, 1'b0};
        end else begin
            tx_frame = '{bl.addr, lprs_pkg::CMD_BACKLIGHT, bl.data, bl.chk, 1'b0};
        end
    end

    // The frame goes to the emitter as built; has_pending is taken from r_after at the output.
    lprs_pkg::t_frame w_frame_q;
    always_comb begin
        w_frame_q = tx_frame;
    end

    lprs_tx u_tx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (tx_start),
        .i_frame (w_frame_q),
        .o_busy  (tx_busy),
        .o_valid (tx_valid),
        .i_ready (i_ready && (r_state == ST_TX)),
        .o_data  (tx_data)
    );

    assign o_ready = (r_state == ST_IDLE);
    always_comb begin
        if (r_state == ST_STAT) begin
            o_valid = r_stat_valid;
            o_data  = '{1'b1, 8'h00, 1'b1, r_stat_hp};
        end else begin
            o_valid = tx_valid && (r_state == ST_TX);
            o_data  = '{tx_data.out_kind, tx_data.tx_byte, tx_data.last, r_after};
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == lprs_pkg::REG_SEND_INTERVAL) ? {24'h0, r_interval} : 32'h0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pend <= '0;
            r_interval <= lprs_pkg::INTERVAL_RESET;
            r_cool <= 8'h00;
            r_next <= '0;
            r_bl_armed <= 1'b0;
            r_bl_step <= 3'd0;
            r_stat_valid <= 1'b0;
            for (int i = 0; i < N; i++) begin
                r_addr[i] <= 8'h00;
                r_want[i] <= 3'd0;
                r_sent[i] <= 3'd0;
            end
        end else begin
            if (psel && penable && pwrite && (paddr == lprs_pkg::REG_SEND_INTERVAL)
                && (pwdata[7:0] != 8'h00)) begin
                r_interval <= pwdata[7:0];
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_req <= i_data;
                        r_cnt <= 6'd0;
                        r_found <= 1'b0;
                        r_free_ok <= 1'b0;
                        case (i_data.action)
                            lprs_pkg::ACT_SET_KEY: r_state <= ST_KEY;
                            lprs_pkg::ACT_REFRESH: begin
                                for (int i = 0; i < N; i++) begin
                                    if (r_addr[i] != 8'h00) r_pend[i] <= 1'b1;
                                end
                            end
                            lprs_pkg::ACT_BACKLIGHT: begin
                                r_bl_armed <= 1'b1;
                                r_bl_step <= 3'd0;
                            end
                            lprs_pkg::ACT_TICK: begin
                                if (r_cool != 8'h00) r_cool <= r_cool - 8'd1;
                            end
                            lprs_pkg::ACT_PROCESS: begin
                                if (r_cool == 8'h00 && !i_data.rx_busy) r_state <= ST_SCAN;
                            end
                            lprs_pkg::ACT_STATUS: begin
                                r_state <= ST_STAT;
                                r_stat_valid <= 1'b1;
                                r_stat_hp <= w_any;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_KEY: begin
                    // One slot compared per cycle; the final cycle updates.
                    if (!w_key_ok) begin
                        r_state <= ST_IDLE;
                    end else if (r_cnt < 6'(N) && !r_found) begin
                        if (r_addr[SW'(r_cnt)] == r_req.panel_address) begin
                            r_found <= 1'b1;
                            r_slot <= SW'(r_cnt);
                        end else begin
                            if (!r_free_ok && r_addr[SW'(r_cnt)] == 8'h00) begin
                                r_free_ok <= 1'b1;
                                r_free <= SW'(r_cnt);
                            end
                            r_cnt <= r_cnt + 6'd1;
                        end
                    end else begin
                        r_state <= ST_IDLE;
                        if (r_found) begin
                            r_want[r_slot] <= w_nw;
                            if (w_nw != r_sent[r_slot]) r_pend[r_slot] <= 1'b1;
                        end else if (r_free_ok) begin
                            r_addr[r_free] <= r_req.panel_address;
                            r_sent[r_free] <= 3'd0;
                            r_want[r_free] <= w_nw;
                            r_pend[r_free] <= (w_nw != 3'd0);
                        end
                    end
                end
                ST_SCAN: begin
                    if (r_cnt < 6'(N)) begin
                        if (w_live[w_idx]) begin
                            r_slot <= w_idx;
                            r_pend[w_idx] <= 1'b0;
                            r_sent[w_idx] <= r_want[w_idx];
                            r_cnt <= 6'd0;
                            r_state <= ST_ROM;
                        end else begin
                            r_cnt <= r_cnt + 6'd1;
                        end
                    end else if (r_bl_armed) begin
                        if (r_bl_step >= 3'(lprs_pkg::BACKLIGHT_FRAMES - 1)) begin
                            r_bl_armed <= 1'b0;
                            r_bl_step <= 3'd0;
                        end else begin
                            r_bl_step <= r_bl_step + 3'd1;
                        end
                        r_cool <= r_interval;
                        r_state <= ST_PEND;
                    end else begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_ROM: begin
                    // Table searched one row per cycle.
                    if (tx_start) begin
                        r_next <= SW'((32'(r_slot) + 1) % N);
                        r_cool <= r_interval;
                        r_state <= ST_PEND;
                    end else if (r_cnt >= 6'(lprs_pkg::ROM_ROWS - 1)) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                ST_PEND: begin
                    r_after <= w_any;
                    r_state <= ST_TX;
                end
                ST_TX: begin
                    if (!tx_busy) r_state <= ST_IDLE;
                end
                ST_STAT: begin
                    if (i_ready) begin
                        r_stat_valid <= 1'b0;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("accepting while a result is shown");
    a_cool_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tx_start && r_state == ST_ROM) |=> r_cool == r_interval)
        else $error("cooldown not reloaded after a frame");
    a_interval_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_interval != 8'h00) else $error("send interval became zero");
endmodule

// ===== tb/sv/lprs_checker.sv =====
// Checker for the LED panel refresh scheduler: watches the request, result and
// configuration ports, predicts the result stream and compares it. Uses lprs_pkg.
module lprs_checker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             o_ready,
    input  lprs_pkg::t_in    i_data,
    input  logic             o_valid,
    input  logic             i_ready,
    input  lprs_pkg::t_out   o_data,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [1:0]       paddr,
    input  logic [31:0]      pwdata,
    input  logic             pready,
    output int               o_errors,
    output int               o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = lprs_pkg::PANEL_SLOTS;

    // Key frame rows: {address, key state, checksum}.
    localparam logic [18:0] KEY_FRAMES [33] = '{
        {8'h01, 3'd1, 8'h44}, {8'h07, 3'd0, 8'h46}, {8'h07, 3'd1, 8'h4E},
        {8'h07, 3'd2, 8'hE0}, {8'h07, 3'd3, 8'h46}, {8'h0D, 3'd0, 8'h60},
        {8'h0D, 3'd1, 8'h08}, {8'h0D, 3'd2, 8'h6A}, {8'h0D, 3'd3, 8'h80},
        {8'h0D, 3'd4, 8'h66}, {8'h0D, 3'd5, 8'h06}, {8'h0E, 3'd0, 8'h68},
        {8'h0E, 3'd1, 8'h6A}, {8'h0E, 3'd2, 8'h60}, {8'h0E, 3'd3, 8'hE6},
        {8'h0E, 3'd4, 8'hE6}, {8'h0E, 3'd5, 8'hEE}, {8'h0E, 3'd6, 8'hE4},
        {8'h0E, 3'd7, 8'h64}, {8'h0F, 3'd0, 8'h6A}, {8'h0F, 3'd1, 8'hE0},
        {8'h0F, 3'd2, 8'hE6}, {8'h0F, 3'd3, 8'hE6}, {8'h0F, 3'd4, 8'hEE},
        {8'h0F, 3'd5, 8'hE4}, {8'h0F, 3'd6, 8'hE4}, {8'h0F, 3'd7, 8'hEA},
        {8'h11, 3'd1, 8'h86}, {8'h11, 3'd0, 8'h06}, {8'h12, 3'd2, 8'hE4},
        {8'h12, 3'd3, 8'hA4}, {8'h12, 3'd0, 8'h46}, {8'h12, 3'd1, 8'h6E}
    };

    // Backlight-off rows: {address, data, checksum}.
    localparam logic [23:0] DIM_FRAMES [6] = '{
        {8'h07, 8'h01, 8'h4E}, {8'h0D, 8'h00, 8'hEA}, {8'h0E, 8'h00, 8'hEA},
        {8'h0F, 8'h00, 8'hAE}, {8'h11, 8'h01, 8'hAE}, {8'h12, 8'h02, 8'hE4}
    };

    logic [7:0] interval;
    logic [7:0] panel_addr [NSLOT];
    logic [2:0] keys_wanted [NSLOT];
    logic [2:0] keys_sent [NSLOT];
    logic       panel_due [NSLOT];
    logic [7:0] cooldown;
    logic [2:0] scan_start;
    logic       dim_armed;
    logic [2:0] dim_step;
    lprs_pkg::t_out bytes_due [$];

    function automatic logic work_waiting();
        logic w;
        w = dim_armed;
        for (int i = 0; i < NSLOT; i++)
            if (panel_addr[i] != 8'h00 && panel_due[i]) w = 1'b1;
        return w;
    endfunction

    task automatic queue_frame(input logic [7:0] a, input logic [7:0] cmd,
                               input logic [7:0] d, input logic [7:0] chk);
        logic [7:0]     fr [8];
        lprs_pkg::t_out b;
        logic           hp;
        hp = work_waiting();
        fr = '{lprs_pkg::FRAME_START, lprs_pkg::FRAME_LEN_CODE, a, cmd, d,
               8'h00, 8'h00, chk};
        for (int k = 0; k < 8; k++) begin
            b.out_kind    = 1'b0;
            b.tx_byte     = fr[k];
            b.last        = (k == 7);
            b.has_pending = hp;
            bytes_due.push_back(b);
        end
    endtask

    task automatic update_key(input lprs_pkg::t_in r);
        int         slot;
        int         spare;
        logic [2:0] mask;
        logic [2:0] st;
        slot  = -1;
        spare = -1;
        if (r.key_number == 8'd0 || r.key_number > 8'd6 || r.panel_address == 8'h00)
            return;
        for (int i = 0; i < NSLOT; i++) begin
            if (slot < 0 && panel_addr[i] == r.panel_address) slot = i;
            if (slot < 0 && spare < 0 && panel_addr[i] == 8'h00) spare = i;
        end
        if (slot < 0) begin
            if (spare < 0) return;
            slot = spare;
            panel_addr[slot]  = r.panel_address;
            keys_wanted[slot] = 3'd0;
            keys_sent[slot]   = 3'd0;
            panel_due[slot]   = 1'b0;
        end
        // Keys 4 to 6 fall outside the three-bit state and leave it as is.
        mask = (r.key_number <= 8'd3) ? 3'(1 << (r.key_number - 1)) : 3'd0;
        st   = r.key_on ? (keys_wanted[slot] | mask) : (keys_wanted[slot] & ~mask);
        keys_wanted[slot] = st;
        if (keys_sent[slot] != st) panel_due[slot] = 1'b1;
    endtask

    task automatic serve_panels(input logic busy);
        int idx;
        if (cooldown != 8'd0 || busy) return;
        for (int off = 0; off < NSLOT; off++) begin
            idx = (int'(scan_start) + off) % NSLOT;
            if (panel_addr[idx] != 8'h00 && panel_due[idx]) begin
                keys_sent[idx] = keys_wanted[idx];
                panel_due[idx] = 1'b0;
                for (int r = 0; r < 33; r++) begin
                    if (KEY_FRAMES[r][18:11] == panel_addr[idx] &&
                        KEY_FRAMES[r][10:8] == keys_wanted[idx]) begin
                        scan_start = 3'((idx + 1) % NSLOT);
                        cooldown   = interval;
                        queue_frame(panel_addr[idx], lprs_pkg::CMD_KEYS,
                                    {5'd0, keys_wanted[idx]}, KEY_FRAMES[r][7:0]);
                        return;
                    end
                end
                return;
            end
        end
        if (dim_armed) begin
            logic [23:0] row;
            row = DIM_FRAMES[dim_step];
            if (dim_step == 3'd5) begin
                dim_armed = 1'b0;
                dim_step  = 3'd0;
            end else begin
                dim_step = dim_step + 3'd1;
            end
            cooldown = interval;
            queue_frame(row[23:16], lprs_pkg::CMD_BACKLIGHT, row[15:8], row[7:0]);
        end
    endtask

    task automatic predict_request(input lprs_pkg::t_in r);
        lprs_pkg::t_out s;
        case (r.action)
            lprs_pkg::ACT_SET_KEY:   update_key(r);
            lprs_pkg::ACT_REFRESH: begin
                for (int i = 0; i < NSLOT; i++)
                    if (panel_addr[i] != 8'h00) panel_due[i] = 1'b1;
            end
            lprs_pkg::ACT_BACKLIGHT: begin
                dim_armed = 1'b1;
                dim_step  = 3'd0;
            end
            lprs_pkg::ACT_TICK: begin
                if (cooldown != 8'd0) cooldown = cooldown - 8'd1;
            end
            lprs_pkg::ACT_PROCESS:   serve_panels(r.rx_busy);
            lprs_pkg::ACT_STATUS: begin
                s.out_kind    = 1'b1;
                s.tx_byte     = 8'h00;
                s.last        = 1'b1;
                s.has_pending = work_waiting();
                bytes_due.push_back(s);
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            interval   = lprs_pkg::INTERVAL_RESET;
            cooldown   = 8'd0;
            scan_start = 3'd0;
            dim_armed  = 1'b0;
            dim_step   = 3'd0;
            for (int i = 0; i < NSLOT; i++) begin
                panel_addr[i]  = 8'h00;
                keys_wanted[i] = 3'd0;
                keys_sent[i]   = 3'd0;
                panel_due[i]   = 1'b0;
            end
            bytes_due.delete();
            o_errors = 0;
        end else begin
            if (psel && penable && pwrite && pready &&
                paddr == lprs_pkg::REG_SEND_INTERVAL && pwdata[7:0] != 8'h00)
                interval = pwdata[7:0];
            if (o_valid && i_ready) begin
                if (bytes_due.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, o_data);
                    o_errors++;
                end else begin
                    lprs_pkg::t_out e;
                    e = bytes_due.pop_front();
                    if (o_data.out_kind !== e.out_kind || o_data.tx_byte !== e.tx_byte ||
                        o_data.last !== e.last || o_data.has_pending !== e.has_pending) begin
                        $display("%0t: mismatch expected %p actual %p", $time, e, o_data);
                        o_errors++;
                    end
                end
            end
            if (i_valid && o_ready) predict_request(i_data);
        end
        o_outstanding = bytes_due.size();
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// Top of the LED panel refresh scheduler testbench: clock, reset, request and
// configuration stimulus, verdict. Depends on lprs_pkg, lprs_checker and the block.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 600000;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_valid = 1'b0;
    logic           o_ready;
    lprs_pkg::t_in  i_data = '0;
    logic           o_valid;
    logic           i_ready = 1'b0;
    lprs_pkg::t_out o_data;
    logic           psel = 1'b0;
    logic           penable = 1'b0;
    logic           pwrite = 1'b0;
    logic [1:0]     paddr = '0;
    logic [31:0]    pwdata = '0;
    logic [31:0]    prdata;
    logic           pready;
    int             errors;
    int             outstanding;
    int             cycles = 0;
    int             send_gap_pct = 0;
    int             stall_pct = 0;
    int             hold_cnt = 0;
    logic           hold_go = 1'b0;

    logic [7:0] known_panels [8] = '{8'h01, 8'h07, 8'h0D, 8'h0E, 8'h0F, 8'h11, 8'h12, 8'h33};

    led_panel_refresh_scheduler dut (.*);

    lprs_checker u_checker (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_data, .o_valid, .i_ready, .o_data,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .o_errors(errors), .o_outstanding(outstanding)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("** led_panel_refresh_scheduler: FAILED **");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off on request.
    always @(posedge i_clk) begin
        if (hold_go) begin
            hold_cnt <= 400;
            i_ready  <= 1'b0;
        end else begin
            if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
            i_ready <= (hold_cnt == 0) && ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send(input lprs_pkg::t_in r);
        if ($urandom_range(99) < send_gap_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= r;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic send_fields(input logic [2:0] act, input logic [7:0] a,
                               input logic [7:0] k, input logic on, input logic busy);
        lprs_pkg::t_in r;
        r = '{act, a, k, on, busy};
        send(r);
    endtask

    // Lets the block drain; requests without results may still be in flight.
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_interval(input logic [7:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= lprs_pkg::REG_SEND_INTERVAL;
        pwdata  <= {24'd0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic lprs_pkg::t_in random_request();
        lprs_pkg::t_in r;
        int            p;
        r = lprs_pkg::t_in'(21'($urandom));
        p = $urandom_range(99);
        if (p < 25)      r.action = lprs_pkg::ACT_SET_KEY;
        else if (p < 30) r.action = lprs_pkg::ACT_REFRESH;
        else if (p < 34) r.action = lprs_pkg::ACT_BACKLIGHT;
        else if (p < 54) r.action = lprs_pkg::ACT_TICK;
        else if (p < 84) r.action = lprs_pkg::ACT_PROCESS;
        else if (p < 96) r.action = lprs_pkg::ACT_STATUS;
        else             r.action = 3'($urandom_range(7, 6));
        if ($urandom_range(99) < 85) r.panel_address = known_panels[$urandom_range(7)];
        if ($urandom_range(99) < 85) r.key_number = 8'($urandom_range(6, 1));
        r.rx_busy = ($urandom_range(99) < 15);
        return r;
    endfunction

    task automatic random_run(input int n);
        repeat (n) send(random_request());
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: table fill, ignored keys, full table, backlight, cooldown.
        send_fields(lprs_pkg::ACT_STATUS, 8'h00, 8'h00, 1'b0, 1'b0);
        send_fields(lprs_pkg::ACT_SET_KEY, 8'h01, 8'd1, 1'b1, 1'b0);
        send_fields(lprs_pkg::ACT_SET_KEY, 8'h07, 8'd2, 1'b1, 1'b0);
        send_fields(lprs_pkg::ACT_SET_KEY, 8'h0D, 8'd3, 1'b1, 1'b0);
        send_fields(lprs_pkg::ACT_SET_KEY, 8'h0E, 8'd1, 1'b1, 1'b0);
        send_fields(lprs_pkg::ACT_SET_KEY, 8'h0F, 8'd5, 1'b1, 1'b0);
        send_fields(lprs_pkg::ACT_SET_KEY, 8'h11, 8'd1, 1'b1, 1'b0);
        send_fields(lprs_pkg::ACT_SET_KEY, 8'h12, 8'd2, 1'b1, 1'b0);
        send_fields(lprs_pkg::ACT_SET_KEY, 8'h33, 8'd1, 1'b1, 1'b0);
        send_fields(lprs_pkg::ACT_SET_KEY, 8'hFF, 8'd1, 1'b1, 1'b1);
        send_fields(lprs_pkg::ACT_SET_KEY, 8'h00, 8'd1, 1'b1, 1'b0);
        send_fields(lprs_pkg::ACT_SET_KEY, 8'h01, 8'd0, 1'b1, 1'b0);
        send_fields(lprs_pkg::ACT_SET_KEY, 8'h01, 8'd7, 1'b1, 1'b0);
        send_fields(lprs_pkg::ACT_SET_KEY, 8'h01, 8'hFF, 1'b1, 1'b0);
        send_fields(lprs_pkg::ACT_PROCESS, 8'h00, 8'h00, 1'b0, 1'b1);
        send_fields(lprs_pkg::ACT_PROCESS, 8'h00, 8'h00, 1'b0, 1'b0);
        send_fields(lprs_pkg::ACT_PROCESS, 8'h00, 8'h00, 1'b0, 1'b0);
        send_fields(lprs_pkg::ACT_TICK, 8'h00, 8'h00, 1'b0, 1'b0);
        send_fields(lprs_pkg::ACT_TICK, 8'h00, 8'h00, 1'b0, 1'b0);
        send_fields(lprs_pkg::ACT_TICK, 8'h00, 8'h00, 1'b0, 1'b0);
        send_fields(lprs_pkg::ACT_BACKLIGHT, 8'h00, 8'h00, 1'b0, 1'b0);
        send_fields(lprs_pkg::ACT_REFRESH, 8'h00, 8'h00, 1'b0, 1'b0);
        send_fields(3'd6, 8'hFF, 8'hFF, 1'b1, 1'b1);
        send_fields(3'd7, 8'h00, 8'h00, 1'b0, 1'b0);
        send_fields(lprs_pkg::ACT_STATUS, 8'h00, 8'h00, 1'b0, 1'b0);
        drain();

        // Shortest interval, no idling; a long output hold-off fills the block.
        write_interval(8'd1);
        random_run(20);
        hold_go <= 1'b1;
        send_fields(lprs_pkg::ACT_REFRESH, 8'h00, 8'h00, 1'b0, 1'b0);
        hold_go <= 1'b0;
        send_fields(lprs_pkg::ACT_BACKLIGHT, 8'h00, 8'h00, 1'b0, 1'b0);
        repeat (6) begin
            send_fields(lprs_pkg::ACT_TICK, 8'h00, 8'h00, 1'b0, 1'b0);
            send_fields(lprs_pkg::ACT_PROCESS, 8'h00, 8'h00, 1'b0, 1'b0);
        end
        random_run(15);
        drain();

        send_gap_pct = 57;
        stall_pct    = 0;
        write_interval(8'd2);
        random_run(35);
        drain();

        // Long interval: a run of ticks is needed between frames,
        // and a zero write leaves the interval as it was.
        send_gap_pct = 0;
        stall_pct    = 57;
        write_interval(8'd40);
        write_interval(8'd0);
        send_fields(lprs_pkg::ACT_REFRESH, 8'h00, 8'h00, 1'b0, 1'b0);
        send_fields(lprs_pkg::ACT_PROCESS, 8'h00, 8'h00, 1'b0, 1'b0);
        random_run(10);
        repeat (40) send_fields(lprs_pkg::ACT_TICK, 8'h00, 8'h00, 1'b0, 1'b0);
        send_fields(lprs_pkg::ACT_PROCESS, 8'h00, 8'h00, 1'b0, 1'b0);
        drain();

        send_gap_pct = 21;
        stall_pct    = 21;
        write_interval(8'd1);
        random_run(35);
        drain();

        send_gap_pct = 0;
        stall_pct    = 0;
        write_interval(8'd7);
        random_run(35);
        drain();

        if (errors == 0) begin
            $display("** led_panel_refresh_scheduler: PASSED **");
        end else begin
            $display("** led_panel_refresh_scheduler: FAILED **");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/lprs_pkg.sv
sv/lprs_tx.sv
sv/led_panel_refresh_scheduler.sv
tb/sv/lprs_checker.sv
tb/sv/tb_top.sv
